@@ rtl/core/alc_pkg.sv @@
package alc_pkg;

  // Lane fields carried by one batch on the ports.
  localparam int LANE_FIELDS = 8;

  // Command codes.
  localparam logic CMD_COMPRESS = 1'b0;
  localparam logic CMD_EXPAND   = 1'b1;

  // A-law coding constants.
  localparam logic [7:0] EVEN_INVERT = 8'h55;
  localparam int         PRE_SHIFT   = 3;
  localparam int         CHORD_LOW   = 5;   // Lowest magnitude bit that opens chord 1.
  localparam int         MAG_TOP     = 11;  // Highest bit of the pre-shifted magnitude.

  // One finished batch as it moves from the lanes into the output buffer.
  typedef struct packed {
    logic [3:0]                   count;
    logic [LANE_FIELDS-1:0][15:0] lane;
  } batch_t;

endpackage

@@ rtl/core/alaw_compand_lanes_top.sv @@
// Batch A-law compander. Each input transfer carries a command, a lane count
// and eight 16-bit lanes; one output transfer carries the count and eight
// result lanes. With cmd at compress, every valid lane turns a signed sample
// into an A-law codeword in bits 7..0 (upper bits zero), with -32768 coded as
// -32767. With cmd at expand, every valid lane turns the codeword in bits 7..0
// into a signed sample. Lanes at or past count, or at or past LANES, return
// zero, and count_out repeats the raw count. The block takes one batch every
// clock cycle while in_stall is low and returns it in the cycle after the
// transfer when the output is not stalled: the LANES coder copies are purely
// combinational and feed a single output register. A two-entry output buffer
// (output register plus a side register) lets a new batch be taken while a
// result still waits, so in_stall only rises once both entries hold a batch.
module alaw_compand_lanes_top #(
  parameter int LANES = 8
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [3:0]  count,
  input  logic [15:0] lane_in_0,
  input  logic [15:0] lane_in_1,
  input  logic [15:0] lane_in_2,
  input  logic [15:0] lane_in_3,
  input  logic [15:0] lane_in_4,
  input  logic [15:0] lane_in_5,
  input  logic [15:0] lane_in_6,
  input  logic [15:0] lane_in_7,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  count_out,
  output logic [15:0] lane_out_0,
  output logic [15:0] lane_out_1,
  output logic [15:0] lane_out_2,
  output logic [15:0] lane_out_3,
  output logic [15:0] lane_out_4,
  output logic [15:0] lane_out_5,
  output logic [15:0] lane_out_6,
  output logic [15:0] lane_out_7
);

  logic [alc_pkg::LANE_FIELDS-1:0][15:0] lane_raw;
  alc_pkg::batch_t                       batch;
  alc_pkg::batch_t                       out_batch;

  assign lane_raw = {lane_in_7, lane_in_6, lane_in_5, lane_in_4,
                     lane_in_3, lane_in_2, lane_in_1, lane_in_0};

  assign batch.count = count;

  // One coder per lane that this build carries; the rest of the ports read
  // back as zero. A lane works only when its index is below the count.
  for (genvar k = 0; k < alc_pkg::LANE_FIELDS; k++) begin : g_lane
    if (k < LANES) begin : g_core
      alc_lane u_lane (
        .cmd      (cmd),
        .en       (count > 4'(k)),
        .lane_in  (lane_raw[k]),
        .lane_out (batch.lane[k])
      );
    end else begin : g_off
      assign batch.lane[k] = 16'd0;
    end
  end

  // Output register and side buffer: every transfer is held here until the
  // consumer takes it.
  alc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_batch  (batch),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_batch (out_batch)
  );

  assign count_out  = out_batch.count;
  assign lane_out_0 = out_batch.lane[0];
  assign lane_out_1 = out_batch.lane[1];
  assign lane_out_2 = out_batch.lane[2];
  assign lane_out_3 = out_batch.lane[3];
  assign lane_out_4 = out_batch.lane[4];
  assign lane_out_5 = out_batch.lane[5];
  assign lane_out_6 = out_batch.lane[6];
  assign lane_out_7 = out_batch.lane[7];

endmodule

@@ rtl/core/alc_lane.sv @@
module alc_lane (
  input  logic        cmd,
  input  logic        en,
  input  logic [15:0] lane_in,
  output logic [15:0] lane_out
);

  logic [15:0] s;
  logic [15:0] s_neg;
  logic        c_sign;
  logic [14:0] mag;
  logic [11:0] m;
  logic [2:0]  c_chord;
  logic [2:0]  sh;
  logic [3:0]  c_step;
  logic [7:0]  code;

  logic [7:0]  e_code;
  logic [2:0]  e_chord;
  logic [3:0]  e_step;
  logic [10:0] e_mag;
  logic [15:0] e_pos;
  logic [15:0] e_val;

  // Compress: the most negative sample is folded onto -32767 first.
  always_comb begin
    s      = (lane_in == 16'h8000) ? 16'h8001 : lane_in;
    s_neg  = ~s + 16'd1;
    c_sign = s[15];
    mag    = c_sign ? s_neg[14:0] : s[14:0];
    m      = mag[14:alc_pkg::PRE_SHIFT];
    c_chord = 3'd0;
    for (int i = alc_pkg::CHORD_LOW; i <= alc_pkg::MAG_TOP; i++) begin
      if (m[i]) begin
        c_chord = 3'(i - (alc_pkg::CHORD_LOW - 1));
      end
    end
    sh     = (c_chord == 3'd0) ? 3'd1 : c_chord;
    c_step = 4'(m >> sh);
    code   = {c_sign, c_chord, c_step} ^ alc_pkg::EVEN_INVERT;
  end

  // Expand: rebuild the segment magnitude and restore the sign.
  always_comb begin
    e_code  = lane_in[7:0] ^ alc_pkg::EVEN_INVERT;
    e_chord = e_code[6:4];
    e_step  = e_code[3:0];
    if (e_chord == 3'd0) begin
      e_mag = {6'd0, e_step, 1'b1};
    end else begin
      e_mag = {6'd0, 1'b1, e_step} << (e_chord - 3'd1);
    end
    e_pos = {2'b00, e_mag, 3'b000};
    e_val = e_code[7] ? (~e_pos + 16'd1) : e_pos;
  end

  always_comb begin
    if (!en) begin
      lane_out = 16'd0;
    end else if (cmd == alc_pkg::CMD_EXPAND) begin
      lane_out = e_val;
    end else begin
      lane_out = {8'd0, code};
    end
  end

endmodule

@@ rtl/core/alc_merge.sv @@
module alc_merge (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  alc_pkg::batch_t in_batch,
  output logic            out_valid,
  input  logic            out_stall,
  output alc_pkg::batch_t out_batch
);

  logic            main_valid;
  logic            skid_valid;
  alc_pkg::batch_t main_data;
  alc_pkg::batch_t skid_data;
  logic            accept;
  logic            out_free;

  assign accept    = in_valid && !skid_valid;
  assign out_free  = !main_valid || !out_stall;
  assign in_stall  = skid_valid;
  assign out_valid = main_valid;
  assign out_batch = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid) begin
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          main_valid <= accept;
        end
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      main_data <= skid_valid ? skid_data : in_batch;
    end
    if (!out_free && accept) begin
      skid_data <= in_batch;
    end
  end

`ifndef SYNTHESIS
  // The side buffer only fills behind a waiting result.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("side buffer holds a batch while the output register is empty");

  // A transfer into a blocked output register lands in the side buffer.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (accept && main_valid && out_stall) |=> (skid_valid && main_valid))
    else $error("batch accepted behind a stalled output was not kept");

  // Draining the side buffer moves its batch into the output register.
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    $fell(skid_valid) |-> main_valid)
    else $error("side buffer emptied without refilling the output register");
`endif

endmodule
